// ===== rtl/delimited_frame_rx_crc16_check_macros.svh =====
`ifndef DELIMITED_FRAME_RX_CRC16_CHECK_MACROS_SVH
`define DELIMITED_FRAME_RX_CRC16_CHECK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DFRX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfrx: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DFRX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfrx: next-cycle check failed");

`endif

// ===== rtl/dfrx_pkg.sv =====
`default_nettype none

package dfrx_pkg;

  localparam int LENGTH_WIDTH  = 16;
  localparam int COUNTER_WIDTH = 32;

  localparam logic [15:0] START_MARKER_RESET = 16'hAABB;
  localparam logic [15:0] END_MARKER_RESET   = 16'hCCDD;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;

  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC_HI  = 2'd2,
    PH_CRC_LO  = 2'd3
  } phase_t;

  // One byte of CRC-16/MODBUS, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/delimited_frame_rx_crc16_check.sv =====
// A result appears in the output register in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless out_ready stalls; the byte-wide CRC update and the
// framing decisions settle between the input port and the state and output registers.
// Reset (rst, synchronous, active high): hunt for the start marker, clear the packet
// counters and the output valid, and restore the markers to 0xAABB and 0xCCDD.
`default_nettype none

module delimited_frame_rx_crc16_check (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // received byte stream
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  rx_byte,
  // payload bytes and end-of-packet status
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             kind,
  output logic [7:0]                       payload_byte,
  output logic                             crc_ok,
  output logic [15:0]                      packet_length,
  output logic [31:0]                      packets_total,
  output logic [31:0]                      packets_lost,
  // register writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [15:0]                 cfg_data
);
  import dfrx_pkg::*;

  // Configuration registers. start_crc1 caches the CRC after the first start marker
  // byte, so the start-of-packet path runs a single byte update.
  logic [15:0] start_marker;
  logic [15:0] end_marker;
  logic [15:0] start_crc1;

  // Framing state
  phase_t                     phase, phase_next;
  logic                       hunt_first_seen, hunt_first_seen_next;
  logic [7:0]                 pending_byte, pending_byte_next;
  logic                       pending_valid, pending_valid_next;
  logic [15:0]                crc_acc, crc_acc_next;
  logic [7:0]                 crc_high_byte, crc_high_byte_next;
  logic [LENGTH_WIDTH-1:0]    payload_length, payload_length_next;
  logic [COUNTER_WIDTH-1:0]   packet_counter, packet_counter_next;
  logic [COUNTER_WIDTH-1:0]   lost_counter, lost_counter_next;

  // Result for the output register
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic        res_ok;

  logic        in_fire;
  logic        start_hit;
  logic        end_hit;
  logic        rx_crc_match;
  logic [15:0] crc_in;
  logic [15:0] crc_new;

  // The output register parts the two sides: take a byte whenever the held result
  // leaves this cycle or there is none.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Second start marker byte after a first one completes the start marker.
  assign start_hit = hunt_first_seen && (rx_byte == start_marker[7:0]);
  // Held byte plus this byte form the end marker; the held byte is then dropped.
  assign end_hit   = pending_valid && (pending_byte == end_marker[15:8]) &&
                     (rx_byte == end_marker[7:0]);
  assign rx_crc_match = ({crc_high_byte, rx_byte} == crc_acc);

  // One shared byte update: seeded from the cached marker CRC while hunting.
  assign crc_in  = (phase == PH_HUNT) ? start_crc1 : crc_acc;
  assign crc_new = crc16_byte(crc_in, rx_byte);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (phase)
        PH_HUNT:    if (start_hit) phase_next = PH_PAYLOAD;
        PH_PAYLOAD: if (end_hit) phase_next = PH_CRC_HI;
        PH_CRC_HI:  phase_next = PH_CRC_LO;
        PH_CRC_LO:  phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  // Datapath and results
  always_comb begin
    hunt_first_seen_next = hunt_first_seen;
    pending_byte_next    = pending_byte;
    pending_valid_next   = pending_valid;
    crc_acc_next         = crc_acc;
    crc_high_byte_next   = crc_high_byte;
    payload_length_next  = payload_length;
    packet_counter_next  = packet_counter;
    lost_counter_next    = lost_counter;
    res_valid            = 1'b0;
    res_kind             = KIND_PAYLOAD;
    res_byte             = 8'h00;
    res_ok               = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (start_hit) begin
            crc_acc_next         = crc_new;
            payload_length_next  = '0;
            pending_valid_next   = 1'b0;
            pending_byte_next    = 8'h00;
            hunt_first_seen_next = 1'b0;
          end else begin
            // A byte that misses the second marker byte may itself open a marker.
            hunt_first_seen_next = (rx_byte == start_marker[15:8]);
          end
        end
        PH_PAYLOAD: begin
          crc_acc_next = crc_new;
          if (end_hit) begin
            pending_valid_next = 1'b0;
            pending_byte_next  = 8'h00;
          end else if (pending_valid) begin
            // Release the held byte, hold the new one.
            res_valid         = 1'b1;
            res_byte          = pending_byte;
            pending_byte_next = rx_byte;
            if (payload_length != '1) payload_length_next = payload_length + 1'b1;
          end else begin
            pending_byte_next  = rx_byte;
            pending_valid_next = 1'b1;
          end
        end
        PH_CRC_HI: begin
          crc_high_byte_next = rx_byte;
        end
        PH_CRC_LO: begin
          packet_counter_next = packet_counter + 1'b1;
          if (!rx_crc_match) lost_counter_next = lost_counter + 1'b1;
          res_valid            = 1'b1;
          res_kind             = KIND_STATUS;
          res_ok               = rx_crc_match;
          hunt_first_seen_next = 1'b0;
        end
        default: begin
          hunt_first_seen_next = 1'b0;
        end
      endcase
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
      start_crc1   <= crc16_byte(CRC_INIT, START_MARKER_RESET[15:8]);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_MARKER: begin
          start_marker <= cfg_data;
          start_crc1   <= crc16_byte(CRC_INIT, cfg_data[15:8]);
        end
        CFG_END_MARKER: end_marker <= cfg_data;
        default: ;
      endcase
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      hunt_first_seen <= 1'b0;
      pending_byte    <= 8'h00;
      pending_valid   <= 1'b0;
      crc_acc         <= CRC_INIT;
      crc_high_byte   <= 8'h00;
      payload_length  <= '0;
      packet_counter  <= '0;
      lost_counter    <= '0;
    end else begin
      phase           <= phase_next;
      hunt_first_seen <= hunt_first_seen_next;
      pending_byte    <= pending_byte_next;
      pending_valid   <= pending_valid_next;
      crc_acc         <= crc_acc_next;
      crc_high_byte   <= crc_high_byte_next;
      payload_length  <= payload_length_next;
      packet_counter  <= packet_counter_next;
      lost_counter    <= lost_counter_next;
    end
  end

  // Output register: load a new result, else drop the one just taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      kind          <= res_kind;
      payload_byte  <= res_byte;
      crc_ok        <= res_ok;
      packet_length <= (res_kind == KIND_STATUS) ? 16'(payload_length) : 16'h0000;
      packets_total <= (res_kind == KIND_STATUS) ? 32'(packet_counter_next) : 32'h0;
      packets_lost  <= (res_kind == KIND_STATUS) ? 32'(lost_counter_next) : 32'h0;
    end
  end

`include "delimited_frame_rx_crc16_check_macros.svh"

  `DFRX_ASSERT_NOW(a_hunt_no_pending, phase == PH_HUNT, !pending_valid)
  `DFRX_ASSERT_NEXT(a_crc_lo_gives_status, in_fire && phase == PH_CRC_LO,
                    out_valid && kind == KIND_STATUS)
  `DFRX_ASSERT_NEXT(a_hunt_leads_to_payload, in_fire && phase == PH_HUNT,
                    phase == PH_HUNT || phase == PH_PAYLOAD)
  `DFRX_ASSERT_NOW(a_status_no_byte, out_valid && kind == KIND_STATUS,
                   payload_byte == 8'h00)
  `DFRX_ASSERT_NOW(a_payload_no_status, out_valid && kind == KIND_PAYLOAD,
                   !crc_ok && packet_length == 16'h0000)

endmodule

`default_nettype wire

// ===== tb/delimited_frame_rx_crc16_check_test.sv =====
`default_nettype none

module delimited_frame_rx_crc16_check_test;
  import dfrx_pkg::*;

  // Register indexes past the end of the register list: the block must drop these writes.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  // Cycles with no transaction on any channel before the run is declared hung.
  // The long receiver hold-off is well below this.
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 250;
  // Idle time given to the block before a register write or the end.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 115;
  localparam int RANDOM_PHASES = 6;
  localparam int DIRECTED_ROWS = 22;
  localparam int MAX_REPORTS   = 10;

  // One result, laid out in the order of the output ports.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        crc_ok;
    logic [15:0] packet_length;
    logic [31:0] packets_total;
    logic [31:0] packets_lost;
  } frame_result_t;

  localparam frame_result_t NO_RESULT = '0;

  // Where a driven byte comes from: typed in, or taken from the running CRC so that
  // the check bytes of a packet come out right (or deliberately wrong).
  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_CRC_HI,
    SRC_CRC_LO,
    SRC_CRC_LO_BAD
  } byte_src_t;

  typedef struct {
    logic [7:0]    value;
    byte_src_t     src;
    bit            typed;
    frame_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        crc_ok;
  logic [15:0] packet_length;
  logic [31:0] packets_total;
  logic [31:0] packets_lost;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  delimited_frame_rx_crc16_check u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .crc_ok       (crc_ok),
    .packet_length(packet_length),
    .packets_total(packets_total),
    .packets_lost (packets_lost),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Clock and reset: reset held from the start, then released for good.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer shadow: own copy of the markers and of the receive state, advanced
  // once per accepted byte by the stimulus process.
  // ---------------------------------------------------------------------------
  logic [15:0]              start_mark = START_MARKER_RESET;
  logic [15:0]              end_mark   = END_MARKER_RESET;
  phase_t                   rx_phase   = PH_HUNT;
  bit                       marker_half_seen = 1'b0;
  logic [7:0]               held_byte  = 8'h00;
  bit                       held_valid = 1'b0;
  logic [15:0]              crc_acc    = CRC_INIT;
  logic [7:0]               crc_hi_rx  = 8'h00;
  logic [LENGTH_WIDTH-1:0]  pay_count  = '0;
  logic [COUNTER_WIDTH-1:0] pkt_count  = '0;
  logic [COUNTER_WIDTH-1:0] lost_count = '0;

  // Results the block still owes, oldest first.
  frame_result_t frame_results_due[$];

  int  bytes_sent   = 0;
  int  fail_count   = 0;
  int  quiet_cycles = 0;
  bit  calm         = 1'b0;  // no idling on either side while set
  bit  hold_phase   = 1'b0;  // asks the receiver for its one long hold-off

  // Reflected CRC-16, shifted one data bit at a time, LSB first.
  function automatic logic [15:0] modbus_crc_update(input logic [15:0] acc,
                                                    input logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ data[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Advance the shadow by one byte; return 1 when the byte releases a result.
  function automatic bit deframe_byte(input logic [7:0] data, output frame_result_t res);
    bit   produced;
    logic matched;
    produced = 1'b0;
    res      = NO_RESULT;
    case (rx_phase)
      PH_HUNT: begin
        // A byte that fails to complete the marker may itself open one.
        if (marker_half_seen && data == start_mark[7:0]) begin
          crc_acc = modbus_crc_update(modbus_crc_update(CRC_INIT, start_mark[15:8]),
                                      start_mark[7:0]);
          pay_count        = '0;
          held_valid       = 1'b0;
          held_byte        = 8'h00;
          marker_half_seen = 1'b0;
          rx_phase         = PH_PAYLOAD;
        end else begin
          marker_half_seen = (data == start_mark[15:8]);
        end
      end
      PH_PAYLOAD: begin
        crc_acc = modbus_crc_update(crc_acc, data);
        if (held_valid && held_byte == end_mark[15:8] && data == end_mark[7:0]) begin
          // Drop the held first end-marker byte; the check bytes follow.
          held_valid = 1'b0;
          held_byte  = 8'h00;
          rx_phase   = PH_CRC_HI;
        end else if (held_valid) begin
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = held_byte;
          produced         = 1'b1;
          if (pay_count != '1) pay_count = pay_count + 1'b1;
          held_byte = data;
        end else begin
          held_byte  = data;
          held_valid = 1'b1;
        end
      end
      PH_CRC_HI: begin
        crc_hi_rx = data;
        rx_phase  = PH_CRC_LO;
      end
      default: begin
        matched   = ({crc_hi_rx, data} == crc_acc);
        pkt_count = pkt_count + 1'b1;
        if (!matched) lost_count = lost_count + 1'b1;
        res.kind          = KIND_STATUS;
        res.crc_ok        = matched;
        res.packet_length = 16'(pay_count);
        res.packets_total = 32'(pkt_count);
        res.packets_lost  = 32'(lost_count);
        produced          = 1'b1;
        rx_phase          = PH_HUNT;
        marker_half_seen  = 1'b0;
      end
    endcase
    return produced;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Typed-in results only where they are obvious: the first
  // packet after reset (empty, bad CRC), the extreme payload bytes and the second
  // status. Every other row is checked against the shadow.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows[DIRECTED_ROWS] = '{
    '{8'h00, SRC_LIT,        1'b0, NO_RESULT},  // noise while hunting
    '{8'hAA, SRC_LIT,        1'b0, NO_RESULT},
    '{8'hAA, SRC_LIT,        1'b0, NO_RESULT},  // repeated first marker byte
    '{8'hBB, SRC_LIT,        1'b0, NO_RESULT},  // start found
    '{8'hCC, SRC_LIT,        1'b0, NO_RESULT},
    '{8'hDD, SRC_LIT,        1'b0, NO_RESULT},  // end right after start: empty packet
    '{8'h00, SRC_CRC_HI,     1'b0, NO_RESULT},
    '{8'h00, SRC_CRC_LO_BAD, 1'b1,
      '{KIND_STATUS, 8'h00, 1'b0, 16'd0, 32'd1, 32'd1}},
    '{8'hFF, SRC_LIT,        1'b0, NO_RESULT},  // hunting starts afresh
    '{8'hAA, SRC_LIT,        1'b0, NO_RESULT},
    '{8'hBB, SRC_LIT,        1'b0, NO_RESULT},
    '{8'hFF, SRC_LIT,        1'b0, NO_RESULT},
    '{8'hAA, SRC_LIT,        1'b1,
      '{KIND_PAYLOAD, 8'hFF, 1'b0, 16'd0, 32'd0, 32'd0}},
    '{8'hBB, SRC_LIT,        1'b0, NO_RESULT},  // start marker inside the payload
    '{8'h00, SRC_LIT,        1'b0, NO_RESULT},
    '{8'hCC, SRC_LIT,        1'b1,
      '{KIND_PAYLOAD, 8'h00, 1'b0, 16'd0, 32'd0, 32'd0}},
    '{8'hCC, SRC_LIT,        1'b0, NO_RESULT},  // half end marker released as payload
    '{8'hDD, SRC_LIT,        1'b0, NO_RESULT},
    '{8'h00, SRC_CRC_HI,     1'b0, NO_RESULT},
    '{8'h00, SRC_CRC_LO,     1'b1,
      '{KIND_STATUS, 8'h00, 1'b1, 16'd5, 32'd2, 32'd1}},
    '{8'hBB, SRC_LIT,        1'b0, NO_RESULT},  // second marker byte alone
    '{8'h55, SRC_LIT,        1'b0, NO_RESULT}
  };

  // ---------------------------------------------------------------------------
  // Byte sender: idle at random, raise valid, hold it with the byte until the
  // transaction completes, then advance the shadow.
  // ---------------------------------------------------------------------------
  task automatic send_rx(input logic [7:0] lit, input byte_src_t src, input bit typed,
                         input frame_result_t want);
    logic [7:0]    data;
    frame_result_t res;
    bit            produced;
    int            gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 25) gap++;
    case (src)
      SRC_CRC_HI:     data = crc_acc[15:8];
      SRC_CRC_LO:     data = crc_acc[7:0];
      SRC_CRC_LO_BAD: data = crc_acc[7:0] ^ 8'h01;
      default:        data = lit;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= data;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    produced = deframe_byte(data, res);
    if (typed) begin
      produced = 1'b1;
      res      = want;
    end
    if (produced) frame_results_due.push_back(res);
  endtask

  task automatic send_plain(input logic [7:0] data);
    send_rx(data, SRC_LIT, 1'b0, NO_RESULT);
  endtask

  // Register write: only once the block has nothing left to deliver.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_START_MARKER) start_mark = data;
    else if (idx == CFG_END_MARKER) end_mark = data;
  endtask

  // Well-formed packet with random content: optional junk, markers, mostly short
  // payload, then mostly good check bytes.
  task automatic send_random_packet();
    int junk;
    int len;
    int pick;
    junk = $urandom_range(2);
    repeat (junk) send_plain(8'($urandom));
    send_plain(start_mark[15:8]);
    send_plain(start_mark[7:0]);
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
    repeat (len) send_plain(8'($urandom));
    send_plain(end_mark[15:8]);
    send_plain(end_mark[7:0]);
    pick = $urandom_range(9);
    if (pick < 8) begin
      send_rx(8'h00, SRC_CRC_HI, 1'b0, NO_RESULT);
      send_rx(8'h00, SRC_CRC_LO, 1'b0, NO_RESULT);
    end else if (pick == 8) begin
      send_rx(8'h00, SRC_CRC_HI, 1'b0, NO_RESULT);
      send_rx(8'h00, SRC_CRC_LO_BAD, 1'b0, NO_RESULT);
    end else begin
      send_plain(8'($urandom));
      send_plain(8'($urandom));
    end
  endtask

  // Line noise, or a packet cut off before its end marker.
  task automatic send_noise();
    int cnt;
    if ($urandom_range(1) == 0) begin
      cnt = $urandom_range(6, 1);
      repeat (cnt) send_plain(8'($urandom));
    end else begin
      send_plain(start_mark[15:8]);
      send_plain(start_mark[7:0]);
      cnt = $urandom_range(4);
      repeat (cnt) send_plain(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random phases under different markers.
  // ---------------------------------------------------------------------------
  localparam logic [15:0] PHASE_START[RANDOM_PHASES] =
    '{16'h0000, 16'hFFFF, 16'h0000, 16'hAABB, 16'h7E7E, 16'h0000};
  localparam logic [15:0] PHASE_END[RANDOM_PHASES] =
    '{16'hFFFF, 16'h0000, 16'h0000, 16'hCCDD, 16'h7E7E, 16'h0000};

  initial begin
    int goal;
    logic [15:0] smark;
    logic [15:0] emark;
    do @(posedge clk); while (rst);

    foreach (directed_rows[i])
      send_rx(directed_rows[i].value, directed_rows[i].src, directed_rows[i].typed,
              directed_rows[i].want);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Phases two and five draw fresh random markers; the rest use fixed corners.
      smark = (p == 2 || p == 5) ? 16'($urandom) : PHASE_START[p];
      emark = (p == 2 || p == 5) ? 16'($urandom) : PHASE_END[p];
      if (p == 0 || p == 5) begin
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
      end
      write_reg(CFG_START_MARKER, smark);
      write_reg(CFG_END_MARKER, emark);
      calm = (p == 2);
      if (p == 3) hold_phase = 1'b1;
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        if ($urandom_range(99) < 85) send_random_packet();
        else send_noise();
      end
    end

    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && frame_results_due.size() == 0) begin
      $display("delimited_frame_rx_crc16_check_test passed");
    end else begin
      $display("delimited_frame_rx_crc16_check_test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one quiet stretch, and one long hold-off
  // counted here while the sender keeps pushing.
  // ---------------------------------------------------------------------------
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_phase && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction against the oldest owed result.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input frame_result_t want,
                               input frame_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: want kind=%0d byte=%02h ok=%0d len=%0d total=%0d lost=%0d", what,
               want.kind, want.payload_byte, want.crc_ok, want.packet_length,
               want.packets_total, want.packets_lost,
               "\n  got kind=%0d byte=%02h ok=%0d len=%0d total=%0d lost=%0d",
               got.kind, got.payload_byte, got.crc_ok, got.packet_length,
               got.packets_total, got.packets_lost);
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{kind, payload_byte, crc_ok, packet_length, packets_total, packets_lost};
      if (frame_results_due.size() == 0) begin
        note_mismatch("result with nothing owed", NO_RESULT, got);
      end else begin
        want = frame_results_due.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.crc_ok !== want.crc_ok || got.packet_length !== want.packet_length ||
            got.packets_total !== want.packets_total ||
            got.packets_lost !== want.packets_lost)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: count edges with no transaction anywhere; give up past the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("delimited_frame_rx_crc16_check_test failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/dfrx_pkg.sv
rtl/delimited_frame_rx_crc16_check.sv
tb/delimited_frame_rx_crc16_check_test.sv
